FILE: rtl/cnrs_pkg.sv
// ----------------------------------------------------------------------------
// cnrs_pkg
// Shared types, constants and the saturating fit function for the cubic
// Newton root solver.
// ----------------------------------------------------------------------------
package cnrs_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int FRAC_BITS_DEF   = 32;
    localparam int DATA_W          = 64;
    localparam int COEF_W          = 16;
    localparam int CNT_W           = 16;
    localparam int IDX_W           = 8;

    localparam logic [COEF_W-1:0] CUBIC_RESET = 16'sd1;
    localparam logic [CNT_W-1:0]  ITER_RESET  = 16'd7800;

    localparam logic [IDX_W-1:0] REG_CUBIC    = 8'd0;
    localparam logic [IDX_W-1:0] REG_SQUARE   = 8'd1;
    localparam logic [IDX_W-1:0] REG_LINEAR   = 8'd2;
    localparam logic [IDX_W-1:0] REG_CONSTANT = 8'd3;
    localparam logic [IDX_W-1:0] REG_ITER     = 8'd4;

    typedef enum logic [3:0] {
        OP_X2 = 4'd0,
        OP_X3 = 4'd1,
        OP_F0 = 4'd2,
        OP_F1 = 4'd3,
        OP_F2 = 4'd4,
        OP_F3 = 4'd5,
        OP_D0 = 4'd6,
        OP_D1 = 4'd7,
        OP_D2 = 4'd8
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_go;
        logic mul_wr;
        logic div_go;
        logic div_wr;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic fd_zero;
    } sts_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } fit_t;

    function automatic fit_t fit_value(input logic neg, input logic [127:0] m,
                                       input logic [DATA_W-1:0] lim_pos);
        logic [DATA_W:0] lim;
        fit_t            r;
        lim = neg ? ({1'b0, lim_pos} + 65'd1) : {1'b0, lim_pos};
        if (m[127:64] != 64'd0 || {1'b0, m[63:0]} > lim) begin
            r.sat = 1'b1;
            r.val = neg ? ~lim_pos : lim_pos;
        end
        else begin
            r.sat = 1'b0;
            r.val = neg ? (64'd0 - m[63:0]) : m[63:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/cubic_newton_root_solver.sv
// ----------------------------------------------------------------------------
// cubic_newton_root_solver
// Newton-Raphson root search on a*x^3+b*x^2+c*x+d in signed fixed point.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to load start_guess; the block then runs
// iteration_count Newton steps and shows one word on root_estimate,
// zero_slope and saturated for a single cycle with done high. The receiver
// cannot stall, so sample on done. Each step runs nine 64x64 multiplies
// through one 32x32 unit, one slope check and a 128-bit bit-serial divide;
// a zero slope ends an item early. The step count resets to 7800. Write
// the coefficient and count registers through the cfg port only while
// busy is low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module cubic_newton_root_solver #(
    parameter int VALUE_WIDTH = cnrs_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = cnrs_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cnrs_pkg::DATA_W-1:0] start_guess,
    output logic                        done,
    output logic [cnrs_pkg::DATA_W-1:0] root_estimate,
    output logic                        zero_slope,
    output logic                        saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cnrs_pkg::IDX_W-1:0]  cfg_index,
    input  logic [cnrs_pkg::COEF_W-1:0] cfg_data
);

    logic [cnrs_pkg::COEF_W-1:0] cubic_reg, square_reg, linear_reg, const_reg;
    logic [cnrs_pkg::CNT_W-1:0]  iter_reg;
    cnrs_pkg::cmd_t              cmd;
    cnrs_pkg::sts_t              sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cubic_reg  <= cnrs_pkg::CUBIC_RESET;
            square_reg <= '0;
            linear_reg <= '0;
            const_reg  <= '0;
            iter_reg   <= cnrs_pkg::ITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cnrs_pkg::REG_CUBIC:    cubic_reg  <= cfg_data;
                cnrs_pkg::REG_SQUARE:   square_reg <= cfg_data;
                cnrs_pkg::REG_LINEAR:   linear_reg <= cfg_data;
                cnrs_pkg::REG_CONSTANT: const_reg  <= cfg_data;
                cnrs_pkg::REG_ITER:     iter_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    cnrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .iter_count (iter_reg),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .flat       (zero_slope)
    );

    cnrs_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .guess         (start_guess),
        .coef_cubic    (cubic_reg),
        .coef_square   (square_reg),
        .coef_linear   (linear_reg),
        .coef_constant (const_reg),
        .estimate      (root_estimate),
        .saturated     (saturated)
    );

endmodule

FILE: rtl/cnrs_mul.sv
// ----------------------------------------------------------------------------
// cnrs_mul
// Signed 64x64 multiplier built from one 32x32 unit over four partial products, with
// optional fraction shift and saturation to the value range.
// ----------------------------------------------------------------------------
module cnrs_mul #(
    parameter int FRAC_BITS = cnrs_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [cnrs_pkg::DATA_W-1:0] a,
    input  logic [cnrs_pkg::DATA_W-1:0] b,
    input  logic                        shift_en,
    input  logic [cnrs_pkg::DATA_W-1:0] lim_pos,
    output logic                        done,
    output logic [cnrs_pkg::DATA_W-1:0] result,
    output logic                        sat
);

    logic [63:0]     ma_reg, mb_reg;
    logic            neg_reg, sh_reg;
    logic [127:0]    acc_reg;
    logic [2:0]      cnt_reg;
    logic            run_reg, done_reg;
    logic [63:0]     res_reg;
    logic            sat_reg;
    logic [31:0]     pa, pb;
    logic [63:0]     pp;
    logic [127:0]    pp_sh;
    logic [127:0]    prod_sh;
    cnrs_pkg::fit_t  fit;

    always_comb
    begin
        pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = pa * pb;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        prod_sh = sh_reg ? (acc_reg >> FRAC_BITS) : acc_reg;
        fit     = cnrs_pkg::fit_value(neg_reg, prod_sh, lim_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 3'd0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ma_reg  <= a[63] ? (64'd0 - a) : a;
            mb_reg  <= b[63] ? (64'd0 - b) : b;
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= shift_en;
            acc_reg <= 128'd0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == 3'd4)
            begin
                res_reg <= fit.val;
                sat_reg <= fit.sat;
            end
            else
            begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign sat    = sat_reg;

endmodule

FILE: rtl/cnrs_div.sv
// ----------------------------------------------------------------------------
// cnrs_div
// Restoring divider, one quotient bit per cycle, computing
// (n << FRAC_BITS) / d truncated toward zero with saturation.
// ----------------------------------------------------------------------------
module cnrs_div #(
    parameter int FRAC_BITS = cnrs_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [cnrs_pkg::DATA_W-1:0] n,
    input  logic [cnrs_pkg::DATA_W-1:0] d,
    input  logic [cnrs_pkg::DATA_W-1:0] lim_pos,
    output logic                        done,
    output logic [cnrs_pkg::DATA_W-1:0] quot,
    output logic                        sat
);

    logic [127:0]   num_reg, q_reg;
    logic [63:0]    dm_reg, rem_reg;
    logic [7:0]     cnt_reg;
    logic           run_reg, done_reg, neg_reg;
    logic [63:0]    res_reg;
    logic           sat_reg;
    logic [63:0]    shifted;
    logic           take;
    logic [63:0]    nmag;
    cnrs_pkg::fit_t fit;

    always_comb
    begin
        shifted = {rem_reg[62:0], num_reg[127]};
        take    = rem_reg[63] || (shifted >= dm_reg);
        nmag    = n[63] ? (64'd0 - n) : n;
        fit     = cnrs_pkg::fit_value(neg_reg, q_reg, lim_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 8'd0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 8'd128)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= {64'd0, nmag} << FRAC_BITS;
            dm_reg  <= d[63] ? (64'd0 - d) : d;
            neg_reg <= n[63] ^ d[63];
            rem_reg <= 64'd0;
            q_reg   <= 128'd0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == 8'd128)
            begin
                res_reg <= fit.val;
                sat_reg <= fit.sat;
            end
            else
            begin
                num_reg <= {num_reg[126:0], 1'b0};
                rem_reg <= take ? (shifted - dm_reg) : shifted;
                q_reg   <= {q_reg[126:0], take};
            end
        end
    end

    assign done = done_reg;
    assign quot = res_reg;
    assign sat  = sat_reg;

endmodule

FILE: rtl/cnrs_dp.sv
// ----------------------------------------------------------------------------
// cnrs_dp
// Datapath: estimate and polynomial registers, operand selection, the
// shared multiplier, the divider, and saturating adds.
// ----------------------------------------------------------------------------
module cnrs_dp #(
    parameter int VALUE_WIDTH = cnrs_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = cnrs_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cnrs_pkg::cmd_t              cmd,
    output cnrs_pkg::sts_t              sts,
    input  logic [cnrs_pkg::DATA_W-1:0] guess,
    input  logic [cnrs_pkg::COEF_W-1:0] coef_cubic,
    input  logic [cnrs_pkg::COEF_W-1:0] coef_square,
    input  logic [cnrs_pkg::COEF_W-1:0] coef_linear,
    input  logic [cnrs_pkg::COEF_W-1:0] coef_constant,
    output logic [cnrs_pkg::DATA_W-1:0] estimate,
    output logic                        saturated
);

    localparam logic [63:0] VMAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;

    logic [63:0]    x_reg, x2_reg, x3_reg, f_reg, fd_reg;
    logic           sat_reg;
    logic [63:0]    cc, cs, cl, ck, cc3, cs2;
    logic [63:0]    op_a, op_b;
    logic           op_sh;
    logic           mul_done, mul_sat, div_done, div_sat;
    logic [63:0]    mul_res, div_q;
    cnrs_pkg::fit_t f_add, fd_add, x_add, g_clamp;

    function automatic cnrs_pkg::fit_t add_sat(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] sum;
        cnrs_pkg::fit_t     r;
        sum = $signed({a[63], a}) + $signed({b[63], b});
        if (sum > $signed({1'b0, VMAX}))
        begin
            r.sat = 1'b1;
            r.val = VMAX;
        end
        else if (sum < $signed({1'b1, ~VMAX}))
        begin
            r.sat = 1'b1;
            r.val = ~VMAX;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = sum[63:0];
        end
        return r;
    endfunction

    always_comb
    begin
        cc  = {{48{coef_cubic[15]}}, coef_cubic};
        cs  = {{48{coef_square[15]}}, coef_square};
        cl  = {{48{coef_linear[15]}}, coef_linear};
        ck  = {{48{coef_constant[15]}}, coef_constant};
        cc3 = cc + (cc << 1);
        cs2 = cs << 1;
        op_sh = 1'b0;
        case (cmd.op)
            cnrs_pkg::OP_X2: begin op_a = x_reg;  op_b = x_reg;  op_sh = 1'b1; end
            cnrs_pkg::OP_X3: begin op_a = x2_reg; op_b = x_reg;  op_sh = 1'b1; end
            cnrs_pkg::OP_F0: begin op_a = cc;     op_b = x3_reg; end
            cnrs_pkg::OP_F1: begin op_a = cs;     op_b = x2_reg; end
            cnrs_pkg::OP_F2: begin op_a = cl;     op_b = x_reg;  end
            cnrs_pkg::OP_F3: begin op_a = ck;     op_b = ONE;    end
            cnrs_pkg::OP_D0: begin op_a = cc3;    op_b = x2_reg; end
            cnrs_pkg::OP_D1: begin op_a = cs2;    op_b = x_reg;  end
            cnrs_pkg::OP_D2: begin op_a = cl;     op_b = ONE;    end
            default:         begin op_a = 64'd0;  op_b = 64'd0;  end
        endcase
        f_add   = add_sat(f_reg, mul_res);
        fd_add  = add_sat(fd_reg, mul_res);
        x_add   = add_sat(x_reg, 64'd0 - div_q);
        g_clamp = add_sat(guess, 64'd0);
    end

    cnrs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.mul_go),
        .a        (op_a),
        .b        (op_b),
        .shift_en (op_sh),
        .lim_pos  (VMAX),
        .done     (mul_done),
        .result   (mul_res),
        .sat      (mul_sat)
    );

    cnrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (cmd.div_go),
        .n       (f_reg),
        .d       (fd_reg),
        .lim_pos (VMAX),
        .done    (div_done),
        .quot    (div_q),
        .sat     (div_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= 64'd0;
            sat_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            x_reg   <= g_clamp.val;
            sat_reg <= g_clamp.sat;
        end
        else if (cmd.div_wr)
        begin
            x_reg   <= x_add.val;
            sat_reg <= sat_reg | div_sat | x_add.sat;
        end
        else if (cmd.mul_wr)
        begin
            case (cmd.op)
                cnrs_pkg::OP_F1, cnrs_pkg::OP_F2, cnrs_pkg::OP_F3:
                    sat_reg <= sat_reg | mul_sat | f_add.sat;
                cnrs_pkg::OP_D1, cnrs_pkg::OP_D2:
                    sat_reg <= sat_reg | mul_sat | fd_add.sat;
                default:
                    sat_reg <= sat_reg | mul_sat;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_wr)
        begin
            case (cmd.op)
                cnrs_pkg::OP_X2: x2_reg <= mul_res;
                cnrs_pkg::OP_X3: x3_reg <= mul_res;
                cnrs_pkg::OP_F0: f_reg  <= mul_res;
                cnrs_pkg::OP_F1, cnrs_pkg::OP_F2, cnrs_pkg::OP_F3: f_reg <= f_add.val;
                cnrs_pkg::OP_D0: fd_reg <= mul_res;
                default:         fd_reg <= fd_add.val;
            endcase
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.fd_zero  = (fd_reg == 64'd0);
    assign estimate     = x_reg;
    assign saturated    = sat_reg;

endmodule

FILE: rtl/cnrs_ctrl.sv
// ----------------------------------------------------------------------------
// cnrs_ctrl
// Controller: sequences the nine multiplies, the zero-slope check, the
// division and the step count of each Newton step.
// ----------------------------------------------------------------------------
module cnrs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cnrs_pkg::CNT_W-1:0] iter_count,
    input  cnrs_pkg::sts_t             sts,
    output cnrs_pkg::cmd_t             cmd,
    output logic                       busy,
    output logic                       done,
    output logic                       flat
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MGO   = 7'b0000010,
        S_MWAIT = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_DGO   = 7'b0010000,
        S_DWAIT = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    cnrs_pkg::op_t              op_reg, op_next;
    logic [cnrs_pkg::CNT_W-1:0] k_reg, k_next;
    logic                       flat_reg, flat_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        flat_next  = flat_reg;
        cmd.load   = 1'b0;
        cmd.mul_go = 1'b0;
        cmd.mul_wr = 1'b0;
        cmd.div_go = 1'b0;
        cmd.div_wr = 1'b0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    flat_next  = 1'b0;
                    op_next    = cnrs_pkg::OP_X2;
                    state_next = (iter_count == '0) ? S_DONE : S_MGO;
                end
            end
            S_MGO:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_wr = 1'b1;
                    if (op_reg == cnrs_pkg::OP_D2)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        op_next    = cnrs_pkg::op_t'(op_reg + 4'd1);
                        state_next = S_MGO;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.fd_zero)
                begin
                    flat_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DGO;
                end
            end
            S_DGO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_wr = 1'b1;
                    k_next     = k_reg + 16'd1;
                    op_next    = cnrs_pkg::OP_X2;
                    state_next = (k_reg + 16'd1 == iter_count) ? S_DONE : S_MGO;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= cnrs_pkg::OP_X2;
            k_reg     <= '0;
            flat_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            flat_reg  <= flat_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign flat = flat_reg;

endmodule

FILE: rtl/cnrs_checker.sv
// ----------------------------------------------------------------------------
// cnrs_checker
// Port-level checks on the start/busy/done sequence of the root solver and on cfg_ready.
// ----------------------------------------------------------------------------
module cnrs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done not a single cycle ending the item");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready dropped");

endmodule

bind cubic_newton_root_solver cnrs_checker u_chk (.*);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for cubic_newton_root_solver. A fixed-point model
// of the Newton loop predicts each result when its start is taken. A checker
// compares every done word field by field with the oldest prediction.
// Directed tests cover the reset state, a zero step count, coefficient and
// guess extremes, a long count cut short by a zero slope, and ignored
// register indexes. Several random coefficient phases follow with short step
// counts. Random gaps are placed before each start.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic signed [cnrs_pkg::DATA_W-1:0] fx_t;

    typedef struct {
        fx_t  root;
        logic flat;
        logic sat;
    } answer_t;

    localparam fx_t            FX_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fx_t            FX_MIN     = 64'sh8000_0000_0000_0000;
    localparam fx_t            FX_ONE     = 64'sh1_0000_0000;
    localparam logic [cnrs_pkg::IDX_W-1:0] REG_SPARE = 8'd5;
    localparam logic [cnrs_pkg::IDX_W-1:0] REG_TOP   = 8'hFF;
    localparam longint         CYCLE_LIMIT = 3000000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [cnrs_pkg::DATA_W-1:0]   start_guess;
    logic                          done;
    logic [cnrs_pkg::DATA_W-1:0]   root_estimate;
    logic                          zero_slope;
    logic                          saturated;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [cnrs_pkg::IDX_W-1:0]    cfg_index;
    logic [cnrs_pkg::COEF_W-1:0]   cfg_data;

    fx_t         m_cubic, m_square, m_linear, m_constant;
    logic [15:0] m_count;
    answer_t     pending_roots[$];
    int          errors;
    longint      cycles;

    cubic_newton_root_solver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_guess   (start_guess),
        .done          (done),
        .root_estimate (root_estimate),
        .zero_slope    (zero_slope),
        .saturated     (saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] mag(input fx_t v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    function automatic fx_t fit_wide(input logic neg, input logic [127:0] m, inout logic sat);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
        if (m > lim)
        begin
            sat = 1'b1;
            return neg ? FX_MIN : FX_MAX;
        end
        return neg ? fx_t'(64'd0 - m[63:0]) : fx_t'(m[63:0]);
    endfunction

    function automatic fx_t mul_clamp(input fx_t a, input fx_t b, input int sh,
                                      inout logic sat);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        p = p >> sh;
        return fit_wide((a < 0) != (b < 0), p, sat);
    endfunction

    function automatic fx_t add_clamp(input fx_t a, input fx_t b, inout logic sat);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(FX_MAX))
        begin
            sat = 1'b1;
            return FX_MAX;
        end
        if (s < 65'(FX_MIN))
        begin
            sat = 1'b1;
            return FX_MIN;
        end
        return fx_t'(s);
    endfunction

    function automatic fx_t div_clamp(input fx_t n, input fx_t d, inout logic sat);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, mag(n)} << cnrs_pkg::FRAC_BITS_DEF;
        q   = num / {64'd0, mag(d)};
        return fit_wide((n < 0) != (d < 0), q, sat);
    endfunction

    function automatic answer_t newton_root(input fx_t guess);
        answer_t r;
        fx_t     x, x2, x3, f, fd;
        logic    sat;
        sat    = 1'b0;
        r.flat = 1'b0;
        x      = guess;
        for (int k = 0; k < m_count; k++)
        begin
            x2 = mul_clamp(x, x, cnrs_pkg::FRAC_BITS_DEF, sat);
            x3 = mul_clamp(x2, x, cnrs_pkg::FRAC_BITS_DEF, sat);
            f  = mul_clamp(m_cubic, x3, 0, sat);
            f  = add_clamp(f, mul_clamp(m_square, x2, 0, sat), sat);
            f  = add_clamp(f, mul_clamp(m_linear, x, 0, sat), sat);
            f  = add_clamp(f, mul_clamp(m_constant, FX_ONE, 0, sat), sat);
            fd = mul_clamp(3 * m_cubic, x2, 0, sat);
            fd = add_clamp(fd, mul_clamp(2 * m_square, x, 0, sat), sat);
            fd = add_clamp(fd, mul_clamp(m_linear, FX_ONE, 0, sat), sat);
            if (fd == 0)
            begin
                r.flat = 1'b1;
                break;
            end
            x = add_clamp(x, -div_clamp(f, fd, sat), sat);
        end
        r.root = x;
        r.sat  = sat;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected word root=%h", $time, root_estimate);
                errors++;
            end
            else
            begin
                answer_t e;
                e = pending_roots.pop_front();
                if (root_estimate !== e.root)
                begin
                    $display("%0t: root_estimate expected %h actual %h",
                             $time, e.root, root_estimate);
                    errors++;
                end
                if (zero_slope !== e.flat)
                begin
                    $display("%0t: zero_slope expected %b actual %b",
                             $time, e.flat, zero_slope);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cubic_newton_root_solver regression: fail");
            $finish;
        end
    end

    task automatic send_guess(input fx_t g);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        while (busy) @(negedge clk);
        start       <= 1'b1;
        start_guess <= g;
        pending_roots.push_back(newton_root(g));
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_roots.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cnrs_pkg::IDX_W-1:0] idx,
                             input logic [cnrs_pkg::COEF_W-1:0] data);
        @(negedge clk);
        start     <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            cnrs_pkg::REG_CUBIC:    m_cubic    = fx_t'($signed(data));
            cnrs_pkg::REG_SQUARE:   m_square   = fx_t'($signed(data));
            cnrs_pkg::REG_LINEAR:   m_linear   = fx_t'($signed(data));
            cnrs_pkg::REG_CONSTANT: m_constant = fx_t'($signed(data));
            cnrs_pkg::REG_ITER:     m_count    = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_poly(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic [15:0] d,
                            input logic [15:0] n);
        wait_idle();
        write_reg(cnrs_pkg::REG_CUBIC, a);
        write_reg(cnrs_pkg::REG_SQUARE, b);
        write_reg(cnrs_pkg::REG_LINEAR, c);
        write_reg(cnrs_pkg::REG_CONSTANT, d);
        write_reg(cnrs_pkg::REG_ITER, n);
    endtask

    task automatic test_reset_state();
        send_guess('0);
    endtask

    task automatic test_zero_count();
        set_poly(16'd1, 16'd0, 16'hFFFE, 16'd0, 16'd0);
        send_guess(FX_ONE * 3);
        send_guess(FX_MIN);
    endtask

    task automatic test_extremes();
        set_poly(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd3);
        send_guess(FX_MAX);
        send_guess(FX_MIN);
        send_guess('0);
        send_guess(FX_ONE);
        send_guess(-FX_ONE);
        set_poly(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd2);
        send_guess(FX_MAX);
        send_guess(FX_MIN);
        send_guess(64'sh5555_5555_AAAA_AAAA);
        set_poly(16'd1, 16'd0, 16'hFFFD, 16'd0, 16'd4);
        send_guess(FX_ONE);
        send_guess(FX_ONE * 2);
        send_guess(-FX_ONE / 2);
        set_poly(16'd1, 16'd0, 16'd0, 16'hFFF8, 16'd12);
        send_guess(FX_ONE * 5);
    endtask

    task automatic test_long_flat();
        set_poly(16'd0, 16'd0, 16'd0, 16'd5, 16'hFFFF);
        send_guess(FX_ONE * 7);
        send_guess(FX_MAX);
    endtask

    task automatic test_spare_index();
        wait_idle();
        write_reg(REG_SPARE, 16'h1234);
        write_reg(REG_TOP, 16'hFFFF);
        write_reg(cnrs_pkg::REG_ITER, 16'd1);
        send_guess(FX_ONE * 2);
    endtask

    task automatic test_random();
        fx_t g;
        for (int ph = 0; ph < 6; ph++)
        begin
            if ($urandom_range(0, 9) < 7)
                set_poly(16'($urandom_range(0, 16) - 8), 16'($urandom_range(0, 16) - 8),
                         16'($urandom_range(0, 16) - 8), 16'($urandom_range(0, 16) - 8),
                         16'($urandom_range(1, 6)));
            else
                set_poly(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom_range(1, 20)));
            for (int i = 0; i < 16; i++)
            begin
                g = fx_t'({$urandom, $urandom});
                if ($urandom_range(0, 9) < 7)
                    g = g >>> 27;
                send_guess(g);
            end
        end
    endtask

    initial
    begin
        errors      = 0;
        cycles      = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        start_guess = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        m_cubic     = 1;
        m_square    = 0;
        m_linear    = 0;
        m_constant  = 0;
        m_count     = cnrs_pkg::ITER_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_zero_count();
        test_extremes();
        test_long_flat();
        test_spare_index();
        test_random();

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("cubic_newton_root_solver regression: pass");
        else
            $display("cubic_newton_root_solver regression: fail");
        $finish;
    end
endmodule
